FILE: design/otac_pkg.sv
// shared types, class codes and helpers for the overlap trim and classify pipeline
package otac_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned SPAN_W  = 16;
    localparam int unsigned CLASS_W = 3;
    localparam logic [SPAN_W-1:0] DEFAULT_MIN_SPAN = SPAN_W'(84);

    localparam logic [CLASS_W-1:0] CLS_INTERNAL         = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_QUERY_CONTAINED  = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_TARGET_CONTAINED = CLASS_W'(2);
    localparam logic [CLASS_W-1:0] CLS_QUERY_TO_TARGET  = CLASS_W'(3);
    localparam logic [CLASS_W-1:0] CLS_TARGET_TO_QUERY  = CLASS_W'(4);

    typedef logic [COORD_W-1:0] t_coord;

    // one input word
    typedef struct packed {
        t_coord query_start;
        t_coord query_stop;
        t_coord target_start;
        t_coord target_stop;
        logic   same_strand;
        t_coord query_region_start;
        t_coord query_region_stop;
        logic   query_dropped;
        t_coord target_region_start;
        t_coord target_region_stop;
        logic   target_dropped;
    } t_overlap;

    // trimmed, clamped overlap handed from trim to measure
    typedef struct packed {
        logic   reject;
        logic   same;
        t_coord qrs;
        t_coord qre;
        t_coord trs;
        t_coord tre;
        t_coord qs;
        t_coord qe;
        t_coord ts;
        t_coord te;
    } t_trimmed;

    // measures handed from measure to class
    typedef struct packed {
        logic   reject;
        t_coord qs;
        t_coord qe;
        t_coord ts;
        t_coord te;
        t_coord ovh;
        t_coord qspan;
        t_coord tspan;
        logic   qb_le_tb;
        logic   qgap_le_tgap;
        logic   tb_le_qb;
        logic   tgap_le_qgap;
        logic   qb_gt_tb;
    } t_measured;

    // one result word
    typedef struct packed {
        logic               kept;
        t_coord             new_query_start;
        t_coord             new_query_stop;
        t_coord             new_target_start;
        t_coord             new_target_stop;
        logic [CLASS_W-1:0] overlap_class;
    } t_result;

    // amount a position lies below the region start
    function automatic t_coord stick_low(input t_coord pos, input t_coord region_start);
        return (pos < region_start) ? (region_start - pos) : '0;
    endfunction

    // amount a position lies above the region stop
    function automatic t_coord stick_high(input t_coord pos, input t_coord region_stop);
        return (pos > region_stop) ? (pos - region_stop) : '0;
    endfunction

    function automatic t_coord min_coord(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_coord max_coord(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: design/otac_if.sv
// valid/ready channel interfaces for overlap input and result words

interface otac_in_if;
    logic                   valid;
    logic                   ready;
    otac_pkg::t_coord       query_start;
    otac_pkg::t_coord       query_stop;
    otac_pkg::t_coord       target_start;
    otac_pkg::t_coord       target_stop;
    logic                   same_strand;
    otac_pkg::t_coord       query_region_start;
    otac_pkg::t_coord       query_region_stop;
    logic                   query_dropped;
    otac_pkg::t_coord       target_region_start;
    otac_pkg::t_coord       target_region_stop;
    logic                   target_dropped;

    modport source (
        output valid, query_start, query_stop, target_start, target_stop, same_strand,
               query_region_start, query_region_stop, query_dropped,
               target_region_start, target_region_stop, target_dropped,
        input  ready
    );
    modport sink (
        input  valid, query_start, query_stop, target_start, target_stop, same_strand,
               query_region_start, query_region_stop, query_dropped,
               target_region_start, target_region_stop, target_dropped,
        output ready
    );
endinterface

interface otac_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kept;
    otac_pkg::t_coord                      new_query_start;
    otac_pkg::t_coord                      new_query_stop;
    otac_pkg::t_coord                      new_target_start;
    otac_pkg::t_coord                      new_target_stop;
    logic [otac_pkg::CLASS_W-1:0]          overlap_class;

    modport source (
        output valid, kept, new_query_start, new_query_stop, new_target_start,
               new_target_stop, overlap_class,
        input  ready
    );
    modport sink (
        input  valid, kept, new_query_start, new_query_stop, new_target_start,
               new_target_stop, overlap_class,
        output ready
    );
endinterface

FILE: design/otac_trim.sv
// trim stages: stick-out amounts, shifted coordinates, second miss test and clamp
module otac_trim (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  otac_pkg::t_overlap    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output otac_pkg::t_trimmed    o_data
);
    import otac_pkg::*;

    typedef struct packed {
        logic   reject;
        logic   same;
        t_coord qrs;
        t_coord qre;
        t_coord trs;
        t_coord tre;
        t_coord qs;
        t_coord qe;
        t_coord ts;
        t_coord te;
        t_coord add_q;
        t_coord sub_q;
        t_coord add_t;
        t_coord sub_t;
    } t_stage_a;

    typedef struct packed {
        logic   reject;
        logic   same;
        t_coord qrs;
        t_coord qre;
        t_coord trs;
        t_coord tre;
        t_coord nqs;
        t_coord nqe;
        t_coord nts;
        t_coord nte;
    } t_stage_b;

    logic     r_va, r_vb, r_vc;
    t_stage_a r_a, n_a;
    t_stage_b r_b, n_b;
    t_trimmed r_c, n_c;
    logic     w_adv_a, w_adv_b, w_adv_c;
    t_coord   w_low_t, w_high_t, w_low_q, w_high_q;

    assign w_adv_c = !r_vc || i_ready;
    assign w_adv_b = !r_vb || w_adv_c;
    assign w_adv_a = !r_va || w_adv_b;
    assign o_ready = w_adv_a;
    assign o_valid = r_vc;
    assign o_data  = r_c;

    // stage a: early reject and strand-dependent stick-out amounts
    always_comb begin
        w_low_t  = stick_low(i_data.target_start, i_data.target_region_start);
        w_high_t = stick_high(i_data.target_stop, i_data.target_region_stop);
        w_low_q  = stick_low(i_data.query_start, i_data.query_region_start);
        w_high_q = stick_high(i_data.query_stop, i_data.query_region_stop);
        n_a.reject = i_data.query_dropped || i_data.target_dropped
                  || (i_data.query_start >= i_data.query_region_stop)
                  || (i_data.query_stop <= i_data.query_region_start)
                  || (i_data.target_start >= i_data.target_region_stop)
                  || (i_data.target_stop <= i_data.target_region_start);
        n_a.same  = i_data.same_strand;
        n_a.qrs   = i_data.query_region_start;
        n_a.qre   = i_data.query_region_stop;
        n_a.trs   = i_data.target_region_start;
        n_a.tre   = i_data.target_region_stop;
        n_a.qs    = i_data.query_start;
        n_a.qe    = i_data.query_stop;
        n_a.ts    = i_data.target_start;
        n_a.te    = i_data.target_stop;
        n_a.add_q = i_data.same_strand ? w_low_t  : w_high_t;
        n_a.sub_q = i_data.same_strand ? w_high_t : w_low_t;
        n_a.add_t = i_data.same_strand ? w_low_q  : w_high_q;
        n_a.sub_t = i_data.same_strand ? w_high_q : w_low_q;
    end

    // stage b: shifted coordinates, wrapping
    always_comb begin
        n_b.reject = r_a.reject;
        n_b.same   = r_a.same;
        n_b.qrs    = r_a.qrs;
        n_b.qre    = r_a.qre;
        n_b.trs    = r_a.trs;
        n_b.tre    = r_a.tre;
        n_b.nqs    = r_a.qs + r_a.add_q;
        n_b.nqe    = r_a.qe - r_a.sub_q;
        n_b.nts    = r_a.ts + r_a.add_t;
        n_b.nte    = r_a.te - r_a.sub_t;
    end

    // stage c: miss test on shifted span, clamp to regions
    always_comb begin
        n_c.reject = r_b.reject
                  || (r_b.nqs >= r_b.qre) || (r_b.nqe <= r_b.qrs)
                  || (r_b.nts >= r_b.tre) || (r_b.nte <= r_b.trs);
        n_c.same = r_b.same;
        n_c.qrs  = r_b.qrs;
        n_c.qre  = r_b.qre;
        n_c.trs  = r_b.trs;
        n_c.tre  = r_b.tre;
        n_c.qs   = max_coord(r_b.nqs, r_b.qrs);
        n_c.qe   = min_coord(r_b.nqe, r_b.qre);
        n_c.ts   = max_coord(r_b.nts, r_b.trs);
        n_c.te   = min_coord(r_b.nte, r_b.tre);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_adv_a) r_va <= i_valid;
            if (w_adv_b) r_vb <= r_va;
            if (w_adv_c) r_vc <= r_vb;
        end
        if (w_adv_a && i_valid) r_a <= n_a;
        if (w_adv_b && r_va)    r_b <= n_b;
        if (w_adv_c && r_vb)    r_c <= n_c;
    end

endmodule

FILE: design/otac_measure.sv
// measure stages: spans, offsets from region ends, length check and overhang
module otac_measure (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [otac_pkg::SPAN_W-1:0]   i_min_span,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  otac_pkg::t_trimmed            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output otac_pkg::t_measured           o_data
);
    import otac_pkg::*;

    typedef struct packed {
        logic   reject;
        logic   order_bad;
        t_coord qs;
        t_coord qe;
        t_coord ts;
        t_coord te;
        t_coord qb;
        t_coord qgap;
        t_coord tb;
        t_coord tgap;
        t_coord qspan;
        t_coord tspan;
    } t_stage_d;

    logic      r_vd, r_ve;
    t_stage_d  r_d, n_d;
    t_measured r_e, n_e;
    logic      w_adv_d, w_adv_e;
    t_coord    w_min;
    t_coord    w_tail_t, w_head_t;

    assign w_adv_e = !r_ve || i_ready;
    assign w_adv_d = !r_vd || w_adv_e;
    assign o_ready = w_adv_d;
    assign o_valid = r_ve;
    assign o_data  = r_e;
    assign w_min   = t_coord'(i_min_span);

    // stage d: offsets from region ends, target side flipped on reverse strand
    always_comb begin
        w_head_t    = i_data.ts - i_data.trs;
        w_tail_t    = i_data.tre - i_data.te;
        n_d.reject    = i_data.reject;
        n_d.order_bad = (i_data.qs >= i_data.qe) || (i_data.ts >= i_data.te);
        n_d.qs    = i_data.qs;
        n_d.qe    = i_data.qe;
        n_d.ts    = i_data.ts;
        n_d.te    = i_data.te;
        n_d.qb    = i_data.qs - i_data.qrs;
        n_d.qgap  = i_data.qre - i_data.qe;
        n_d.tb    = i_data.same ? w_head_t : w_tail_t;
        n_d.tgap  = i_data.same ? w_tail_t : w_head_t;
        n_d.qspan = i_data.qe - i_data.qs;
        n_d.tspan = i_data.te - i_data.ts;
    end

    // stage e: minimum length test, overhang and class compares
    always_comb begin
        n_e.reject = r_d.reject || r_d.order_bad
                  || (r_d.qspan < w_min) || (r_d.tspan < w_min);
        n_e.qs    = r_d.qs;
        n_e.qe    = r_d.qe;
        n_e.ts    = r_d.ts;
        n_e.te    = r_d.te;
        n_e.ovh   = min_coord(r_d.qb, r_d.tb) + min_coord(r_d.qgap, r_d.tgap);
        n_e.qspan = r_d.qspan;
        n_e.tspan = r_d.tspan;
        n_e.qb_le_tb     = r_d.qb <= r_d.tb;
        n_e.qgap_le_tgap = r_d.qgap <= r_d.tgap;
        n_e.tb_le_qb     = r_d.tb <= r_d.qb;
        n_e.tgap_le_qgap = r_d.tgap <= r_d.qgap;
        n_e.qb_gt_tb     = r_d.qb > r_d.tb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (w_adv_d) r_vd <= i_valid;
            if (w_adv_e) r_ve <= r_vd;
        end
        if (w_adv_d && i_valid) r_d <= n_d;
        if (w_adv_e && r_vd)    r_e <= n_e;
    end

endmodule

FILE: design/otac_class.sv
// class stages: span plus overhang sums, 7/8 containment test and result word
module otac_class (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  otac_pkg::t_measured   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output otac_pkg::t_result     o_data
);
    import otac_pkg::*;

    localparam int unsigned PROD_W = COORD_W + 3;

    typedef struct packed {
        logic   reject;
        t_coord qs;
        t_coord qe;
        t_coord ts;
        t_coord te;
        t_coord qspan;
        t_coord tspan;
        t_coord qsum;
        t_coord tsum;
        logic   qb_le_tb;
        logic   qgap_le_tgap;
        logic   tb_le_qb;
        logic   tgap_le_qgap;
        logic   qb_gt_tb;
    } t_stage_f;

    logic                r_vf, r_vg;
    t_stage_f            r_f, n_f;
    t_result             r_g, n_g;
    logic                w_adv_f, w_adv_g;
    logic [PROD_W-1:0]   w_q8, w_t8, w_q7, w_t7;
    logic                w_internal;
    logic [CLASS_W-1:0]  w_cls;

    assign w_adv_g = !r_vg || i_ready;
    assign w_adv_f = !r_vf || w_adv_g;
    assign o_ready = w_adv_f;
    assign o_valid = r_vg;
    assign o_data  = r_g;

    // stage f: span plus overhang, wrapping at 32 bits
    always_comb begin
        n_f.reject       = i_data.reject;
        n_f.qs           = i_data.qs;
        n_f.qe           = i_data.qe;
        n_f.ts           = i_data.ts;
        n_f.te           = i_data.te;
        n_f.qspan        = i_data.qspan;
        n_f.tspan        = i_data.tspan;
        n_f.qsum         = i_data.qspan + i_data.ovh;
        n_f.tsum         = i_data.tspan + i_data.ovh;
        n_f.qb_le_tb     = i_data.qb_le_tb;
        n_f.qgap_le_tgap = i_data.qgap_le_tgap;
        n_f.tb_le_qb     = i_data.tb_le_qb;
        n_f.tgap_le_qgap = i_data.tgap_le_qgap;
        n_f.qb_gt_tb     = i_data.qb_gt_tb;
    end

    // stage g: 8*span against 7*sum, exact in 35 bits
    always_comb begin
        w_q8 = {r_f.qspan, 3'b000};
        w_t8 = {r_f.tspan, 3'b000};
        w_q7 = {r_f.qsum, 3'b000} - PROD_W'(r_f.qsum);
        w_t7 = {r_f.tsum, 3'b000} - PROD_W'(r_f.tsum);
        w_internal = (w_q8 < w_q7) || (w_t8 < w_t7);
        if (w_internal) begin
            w_cls = CLS_INTERNAL;
        end else if (r_f.qb_le_tb && r_f.qgap_le_tgap) begin
            w_cls = CLS_QUERY_CONTAINED;
        end else if (r_f.tb_le_qb && r_f.tgap_le_qgap) begin
            w_cls = CLS_TARGET_CONTAINED;
        end else if (r_f.qb_gt_tb) begin
            w_cls = CLS_QUERY_TO_TARGET;
        end else begin
            w_cls = CLS_TARGET_TO_QUERY;
        end
        if (r_f.reject) begin
            n_g = '0;
        end else begin
            n_g.kept             = 1'b1;
            n_g.new_query_start  = r_f.qs;
            n_g.new_query_stop   = r_f.qe;
            n_g.new_target_start = r_f.ts;
            n_g.new_target_stop  = r_f.te;
            n_g.overlap_class    = w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else begin
            if (w_adv_f) r_vf <= i_valid;
            if (w_adv_g) r_vg <= r_vf;
        end
        if (w_adv_f && i_valid) r_f <= n_f;
        if (w_adv_g && r_vf)    r_g <= n_g;
    end

endmodule

FILE: design/overlap_trim_and_classify.sv
// top level of the overlap trim and classify pipeline
// overlap trim and classify: one overlap word in, one result word out, in order.
// throughput is one word per clock while o_out does not stall, through the seven
// register stages (three trim, two measure, two class). every stage has its own
// valid bit and takes a new word whenever it is empty or its successor moves, so
// bubbles collapse and a stall on o_out backs up stage by stage without losing or
// repeating anything; i_in.ready stays high while the pipeline still has an empty
// stage. a rejected overlap (dropped read, miss of a valid region, empty or inverted
// clamped span, span under min_overlap_span) comes out with kept low and all
// coordinates and the class at zero. min_overlap_span resets to 84 and should only
// be written while the pipeline is empty.
module overlap_trim_and_classify #(
    parameter logic [otac_pkg::SPAN_W-1:0] MIN_SPAN_RESET = otac_pkg::DEFAULT_MIN_SPAN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [otac_pkg::SPAN_W-1:0]   i_cfg_wr_data,
    otac_in_if.sink                       i_in,
    otac_out_if.source                    o_out
);
    import otac_pkg::*;

    logic [SPAN_W-1:0] r_min_span;
    t_overlap          w_in_word;
    t_trimmed          w_trim_data;
    t_measured         w_meas_data;
    t_result           w_res_data;
    logic              w_trim_valid, w_trim_ready;
    logic              w_meas_valid, w_meas_ready;

    // minimum span register; the user must write it only when idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_span <= MIN_SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_span <= i_cfg_wr_data;
        end
    end

    // gather the input word into one bundle
    always_comb begin
        w_in_word.query_start         = i_in.query_start;
        w_in_word.query_stop          = i_in.query_stop;
        w_in_word.target_start        = i_in.target_start;
        w_in_word.target_stop         = i_in.target_stop;
        w_in_word.same_strand         = i_in.same_strand;
        w_in_word.query_region_start  = i_in.query_region_start;
        w_in_word.query_region_stop   = i_in.query_region_stop;
        w_in_word.query_dropped       = i_in.query_dropped;
        w_in_word.target_region_start = i_in.target_region_start;
        w_in_word.target_region_stop  = i_in.target_region_stop;
        w_in_word.target_dropped      = i_in.target_dropped;
    end

    // stick-out, shift and clamp
    otac_trim u_trim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (w_in_word),
        .o_valid (w_trim_valid),
        .i_ready (w_trim_ready),
        .o_data  (w_trim_data)
    );

    // spans, length check, overhang
    otac_measure u_measure (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_span (r_min_span),
        .i_valid    (w_trim_valid),
        .o_ready    (w_trim_ready),
        .i_data     (w_trim_data),
        .o_valid    (w_meas_valid),
        .i_ready    (w_meas_ready),
        .o_data     (w_meas_data)
    );

    // containment test and final result register
    otac_class u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_meas_valid),
        .o_ready (w_meas_ready),
        .i_data  (w_meas_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_res_data)
    );

    // spread the result word onto the output channel
    assign o_out.kept             = w_res_data.kept;
    assign o_out.new_query_start  = w_res_data.new_query_start;
    assign o_out.new_query_stop   = w_res_data.new_query_stop;
    assign o_out.new_target_start = w_res_data.new_target_start;
    assign o_out.new_target_stop  = w_res_data.new_target_stop;
    assign o_out.overlap_class    = w_res_data.overlap_class;

endmodule
